### sv/sequence_reorder_buffer_core_defines.svh
// assertion macros for the sequence reorder buffer
// expects clk_i and rst_ni in the scope where a macro is used
`ifndef SEQUENCE_REORDER_BUFFER_CORE_DEFINES_SVH
`define SEQUENCE_REORDER_BUFFER_CORE_DEFINES_SVH

// consequent holds in the same cycle as the antecedent
`define SRB_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define SRB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

### sv/srb_pkg.sv
// shared types and constants for the sequence reorder buffer
// no dependencies
package srb_pkg;

  // default number of reorder slots
  localparam int WINDOW_DEFAULT = 32;

  // field widths
  localparam int SEQ_W  = 32;
  localparam int CHAN_W = 16;
  localparam int HDL_W  = 16;
  localparam int LEN_W  = 16;
  localparam int CNT_W  = 16;

  // result status codes
  typedef enum logic [2:0] {
    ST_DELIVERED     = 3'd0,
    ST_BUFFERED      = 3'd1,
    ST_DUPLICATE     = 3'd2,
    ST_OUT_OF_WINDOW = 3'd3,
    ST_WRONG_CHANNEL = 3'd4,
    ST_BAD_MAGIC     = 3'd5,
    ST_BAD_INTEGRITY = 3'd6
  } status_e;

endpackage

### sv/sequence_reorder_buffer_core.sv
// sequence reorder buffer top level: packet descriptor classification and in-order drain
// depends on srb_pkg and sequence_reorder_buffer_core_defines.svh
//
// A descriptor is taken when start is high and busy is low. The block then
// answers with one or more results, each shown for exactly one cycle with
// strobe_o high; the receiver cannot stall, so it must take a result in the
// cycle it appears. A descriptor that delivers nothing, or that delivers only
// itself, is captured, then classified and answered, and busy stays high
// until that answer is registered. A descriptor that releases buffered
// packets, up to WINDOW-1 of them, keeps busy high while they drain, because
// the slot memory is read through one registered port, one slot per cycle;
// those results come on consecutive cycles and the one with last_o high ends the
// item. The target channel register may be written at any time the block is idle.
`include "sequence_reorder_buffer_core_defines.svh"

module sequence_reorder_buffer_core #(
  parameter int WINDOW = srb_pkg::WINDOW_DEFAULT
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // configuration
  input  logic                      cfg_we_i,
  input  logic [srb_pkg::CHAN_W-1:0] cfg_wdata_i,
  // descriptor input
  input  logic                      start,
  output logic                      busy,
  input  logic [srb_pkg::SEQ_W-1:0]  sequence_req_i,
  input  logic [srb_pkg::CHAN_W-1:0] channel_i,
  input  logic                      magic_ok_i,
  input  logic                      integrity_ok_i,
  input  logic [srb_pkg::HDL_W-1:0]  payload_handle_i,
  input  logic [srb_pkg::LEN_W-1:0]  payload_length_i,
  // results
  output logic                      strobe_o,
  output logic [2:0]                status_o,
  output logic [srb_pkg::SEQ_W-1:0]  delivered_sequence_o,
  output logic [srb_pkg::HDL_W-1:0]  out_handle_o,
  output logic [srb_pkg::LEN_W-1:0]  out_length_o,
  output logic                      last_o,
  output logic [srb_pkg::CNT_W-1:0]  reorder_total_o
);

  localparam int IW    = $clog2(WINDOW);
  localparam int CW    = $clog2(WINDOW + 1);
  localparam int SW    = srb_pkg::SEQ_W;
  localparam int MW    = srb_pkg::HDL_W + srb_pkg::LEN_W;

  localparam logic [SW-1:0] Win32   = SW'(WINDOW);
  localparam logic [IW:0]   WinIdx  = (IW+1)'(WINDOW);
  localparam logic [IW-1:0] LastIdx = IW'(WINDOW - 1);
  localparam logic [CW-1:0] WinCnt  = CW'(WINDOW);
  localparam logic [srb_pkg::CNT_W-1:0] CntMax = '1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EVAL,
    S_DRAIN
  } state_e;

  // slot index after advancing the expected sequence by one
  function automatic logic [IW-1:0] next_idx(input logic [SW-1:0] nexp,
                                             input logic [IW-1:0] cur);
    logic [IW-1:0] r;
    if (nexp == '0) begin
      r = '0;
    end else if (cur == LastIdx) begin
      r = '0;
    end else begin
      r = cur + 1'b1;
    end
    return r;
  endfunction

  // candidate lies at most WINDOW past the highest seen sequence
  function automatic logic near_ok(input logic [SW-1:0] nx,
                                   input logic [SW-1:0] hi);
    logic [SW-1:0] ahead;
    ahead = nx - hi;
    return (ahead <= Win32) || ahead[SW-1];
  endfunction

  // control and state registers
  state_e                     state_q, state_d;
  logic [SW-1:0]              exp_q, exp_d;
  logic [IW-1:0]              exp_idx_q, exp_idx_d;
  logic [SW-1:0]              high_q, high_d;
  logic [srb_pkg::CNT_W-1:0]  reorder_q, reorder_d;
  logic [WINDOW-1:0]          valid_q, valid_d;
  logic [CW-1:0]              cnt_q, cnt_d;
  logic [srb_pkg::CHAN_W-1:0] target_q, target_d;

  // captured descriptor
  logic [SW-1:0]              seq_q, seq_d;
  logic [srb_pkg::CHAN_W-1:0] chan_q, chan_d;
  logic                       magic_q, magic_d;
  logic                       integ_q, integ_d;
  logic [srb_pkg::HDL_W-1:0]  handle_q, handle_d;
  logic [srb_pkg::LEN_W-1:0]  length_q, length_d;

  // registered result
  logic                       strobe_q, strobe_d;
  srb_pkg::status_e           status_q, status_d;
  logic [SW-1:0]              dseq_q, dseq_d;
  logic [srb_pkg::HDL_W-1:0]  ohdl_q, ohdl_d;
  logic [srb_pkg::LEN_W-1:0]  olen_q, olen_d;
  logic                       last_q, last_d;
  logic [srb_pkg::CNT_W-1:0]  total_q, total_d;

  // slot memory: handle in the upper half, length in the lower half
  logic [MW-1:0]              slot_mem [WINDOW];
  logic [MW-1:0]              mem_rd_q;
  logic                       mem_we;
  logic [IW-1:0]              mem_waddr;
  logic [IW-1:0]              mem_raddr;

  // classification datapath
  logic [SW-1:0]              diff;
  logic [SW-1:0]              neg_diff;
  logic [SW-1:0]              seq_inc;
  logic [SW-1:0]              exp_inc;
  logic [SW-1:0]              up_diff;
  logic                       seq_wrapped;
  logic [IW:0]                idx_sum;
  logic [IW-1:0]              buf_idx;
  logic [IW-1:0]              eval_nidx;
  logic [IW-1:0]              drain_nidx;
  logic [CW-1:0]              cnt_inc;

  assign diff        = seq_q - exp_q;
  assign neg_diff    = '0 - diff;
  assign seq_inc     = seq_q + 1'b1;
  assign exp_inc     = exp_q + 1'b1;
  assign up_diff     = seq_q - high_q;
  assign cnt_inc     = cnt_q + 1'b1;
  assign eval_nidx   = next_idx(seq_inc, exp_idx_q);
  assign drain_nidx  = next_idx(exp_inc, exp_idx_q);

  // slot of a future packet: expected slot plus offset, or the raw sequence
  // when the sum passed the 32-bit wrap
  assign seq_wrapped = seq_q < exp_q;
  assign idx_sum     = {1'b0, exp_idx_q} + diff[IW:0];
  always_comb begin
    if (seq_wrapped) begin
      buf_idx = seq_q[IW-1:0];
    end else if (idx_sum >= WinIdx) begin
      buf_idx = IW'(idx_sum - WinIdx);
    end else begin
      buf_idx = idx_sum[IW-1:0];
    end
  end

  // next-state and result logic
  always_comb begin
    state_d   = state_q;
    exp_d     = exp_q;
    exp_idx_d = exp_idx_q;
    high_d    = high_q;
    reorder_d = reorder_q;
    valid_d   = valid_q;
    cnt_d     = cnt_q;
    target_d  = cfg_we_i ? cfg_wdata_i : target_q;
    seq_d     = seq_q;
    chan_d    = chan_q;
    magic_d   = magic_q;
    integ_d   = integ_q;
    handle_d  = handle_q;
    length_d  = length_q;
    strobe_d  = 1'b0;
    status_d  = status_q;
    dseq_d    = dseq_q;
    ohdl_d    = ohdl_q;
    olen_d    = olen_q;
    last_d    = last_q;
    total_d   = total_q;
    mem_we    = 1'b0;
    mem_waddr = buf_idx;
    mem_raddr = eval_nidx;

    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          seq_d    = sequence_req_i;
          chan_d   = channel_i;
          magic_d  = magic_ok_i;
          integ_d  = integrity_ok_i;
          handle_d = payload_handle_i;
          length_d = payload_length_i;
          state_d  = S_EVAL;
        end
      end

      S_EVAL: begin
        state_d  = S_IDLE;
        strobe_d = 1'b1;
        last_d   = 1'b1;
        dseq_d   = seq_q;
        ohdl_d   = '0;
        olen_d   = '0;
        total_d  = reorder_q;
        if (!magic_q) begin
          status_d = srb_pkg::ST_BAD_MAGIC;
        end else if (chan_q != target_q) begin
          status_d = srb_pkg::ST_WRONG_CHANNEL;
        end else if (!integ_q) begin
          status_d = srb_pkg::ST_BAD_INTEGRITY;
        end else if (diff == '0) begin
          // in order: deliver now, drain if the following slot is filled
          status_d  = srb_pkg::ST_DELIVERED;
          ohdl_d    = handle_q;
          olen_d    = length_q;
          exp_d     = seq_inc;
          exp_idx_d = eval_nidx;
          high_d    = seq_q;
          mem_raddr = eval_nidx;
          cnt_d     = CW'(1);
          if (valid_q[eval_nidx]) begin
            last_d  = 1'b0;
            state_d = S_DRAIN;
          end
        end else if (diff < Win32) begin
          // future packet inside the window
          if (valid_q[buf_idx]) begin
            status_d = srb_pkg::ST_DUPLICATE;
          end else begin
            status_d         = srb_pkg::ST_BUFFERED;
            mem_we           = 1'b1;
            valid_d[buf_idx] = 1'b1;
            if (reorder_q != CntMax) begin
              reorder_d = reorder_q + 1'b1;
            end
            total_d = reorder_d;
            if ((up_diff != '0) && !up_diff[SW-1]) begin
              high_d = seq_q;
            end
          end
        end else if (neg_diff < Win32) begin
          status_d = srb_pkg::ST_DUPLICATE;
        end else begin
          status_d = srb_pkg::ST_OUT_OF_WINDOW;
        end
      end

      S_DRAIN: begin
        // deliver the slot read last cycle, look ahead one slot
        strobe_d           = 1'b1;
        status_d           = srb_pkg::ST_DELIVERED;
        dseq_d             = exp_q;
        ohdl_d             = mem_rd_q[MW-1:srb_pkg::LEN_W];
        olen_d             = mem_rd_q[srb_pkg::LEN_W-1:0];
        total_d            = reorder_q;
        valid_d[exp_idx_q] = 1'b0;
        exp_d              = exp_inc;
        exp_idx_d          = drain_nidx;
        cnt_d              = cnt_inc;
        mem_raddr          = drain_nidx;
        if ((cnt_inc < WinCnt) && valid_q[drain_nidx] && near_ok(exp_inc, high_q)) begin
          last_d = 1'b0;
        end else begin
          last_d  = 1'b1;
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // state, captured descriptor and registered result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      exp_q     <= '0;
      exp_idx_q <= '0;
      high_q    <= '0;
      reorder_q <= '0;
      valid_q   <= '0;
      cnt_q     <= '0;
      target_q  <= '0;
      seq_q     <= '0;
      chan_q    <= '0;
      magic_q   <= 1'b0;
      integ_q   <= 1'b0;
      handle_q  <= '0;
      length_q  <= '0;
      strobe_q  <= 1'b0;
      status_q  <= srb_pkg::ST_DELIVERED;
      dseq_q    <= '0;
      ohdl_q    <= '0;
      olen_q    <= '0;
      last_q    <= 1'b0;
      total_q   <= '0;
    end else begin
      state_q   <= state_d;
      exp_q     <= exp_d;
      exp_idx_q <= exp_idx_d;
      high_q    <= high_d;
      reorder_q <= reorder_d;
      valid_q   <= valid_d;
      cnt_q     <= cnt_d;
      target_q  <= target_d;
      seq_q     <= seq_d;
      chan_q    <= chan_d;
      magic_q   <= magic_d;
      integ_q   <= integ_d;
      handle_q  <= handle_d;
      length_q  <= length_d;
      strobe_q  <= strobe_d;
      status_q  <= status_d;
      dseq_q    <= dseq_d;
      ohdl_q    <= ohdl_d;
      olen_q    <= olen_d;
      last_q    <= last_d;
      total_q   <= total_d;
    end
  end

  // slot memory, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      slot_mem[mem_waddr] <= {handle_q, length_q};
    end
    mem_rd_q <= slot_mem[mem_raddr];
  end

  // outputs
  assign busy                 = (state_q != S_IDLE);
  assign strobe_o             = strobe_q;
  assign status_o             = status_q;
  assign delivered_sequence_o = dseq_q;
  assign out_handle_o         = ohdl_q;
  assign out_length_o         = olen_q;
  assign last_o               = last_q;
  assign reorder_total_o      = total_q;

  // checks
  `SRB_ASSERT_NEXT(a_drain_gapless, strobe_o && !last_o, strobe_o, "drain result missing")
  `SRB_ASSERT_NEXT(a_drain_consecutive, strobe_o && !last_o, delivered_sequence_o == $past(delivered_sequence_o) + 1'b1, "drain sequence not consecutive")
  `SRB_ASSERT_SAME(a_status_single, strobe_o && (status_o != srb_pkg::ST_DELIVERED), last_o && (out_handle_o == '0) && (out_length_o == '0), "non-delivery result malformed")
  `SRB_ASSERT_SAME(a_busy_during_drain, strobe_o && !last_o, busy, "drain while idle")

endmodule

### sim/tb.sv
// testbench for sequence_reorder_buffer_core: bursty descriptor driver, result monitor
// and a cycle-free predictor of classification, slot buffering and in-order drain
// depends on srb_pkg and the sequence_reorder_buffer_core rtl
`timescale 1ns / 100ps

module tb;

  localparam int WIN = srb_pkg::WINDOW_DEFAULT;
  localparam int SETTLE_CYCLES = WIN + 4;
  localparam int SEQ_W  = srb_pkg::SEQ_W;
  localparam int CHAN_W = srb_pkg::CHAN_W;
  localparam int HDL_W  = srb_pkg::HDL_W;
  localparam int LEN_W  = srb_pkg::LEN_W;
  localparam int CNT_W  = srb_pkg::CNT_W;

  // one packet descriptor
  typedef struct {
    logic [SEQ_W-1:0]  seq;
    logic [CHAN_W-1:0] chan;
    logic              magic;
    logic              integ;
    logic [HDL_W-1:0]  hdl;
    logic [LEN_W-1:0]  len;
  } desc_t;

  // one result as the block reports it
  typedef struct {
    srb_pkg::status_e  status;
    logic [SEQ_W-1:0]  seq;
    logic [HDL_W-1:0]  hdl;
    logic [LEN_W-1:0]  len;
    logic              last;
    logic [CNT_W-1:0]  total;
  } result_t;

  logic clk_i = 1'b0;
  logic rst_n = 1'b0;

  logic              cfg_we = 1'b0;
  logic [CHAN_W-1:0] cfg_wdata = '0;
  logic              start_r = 1'b0;
  logic              busy;
  logic [SEQ_W-1:0]  seq_r = '0;
  logic [CHAN_W-1:0] chan_r = '0;
  logic              magic_r = 1'b0;
  logic              integ_r = 1'b0;
  logic [HDL_W-1:0]  hdl_r = '0;
  logic [LEN_W-1:0]  len_r = '0;

  logic              strobe_o;
  logic [2:0]        status_o;
  logic [SEQ_W-1:0]  delivered_sequence_o;
  logic [HDL_W-1:0]  out_handle_o;
  logic [LEN_W-1:0]  out_length_o;
  logic              last_o;
  logic [CNT_W-1:0]  reorder_total_o;

  desc_t   desc_q[$];
  result_t result_q[$];
  desc_t   cur_desc;
  int      err_cnt = 0;
  int      gap_left = 0;
  int      burst_left = 4;

  // shadow state of the reorder buffer
  logic [CHAN_W-1:0] sh_target = '0;
  logic [SEQ_W-1:0]  sh_expected = '0;
  logic [SEQ_W-1:0]  sh_highest = '0;
  logic              sh_valid [WIN];
  logic [HDL_W-1:0]  sh_hdl [WIN];
  logic [LEN_W-1:0]  sh_len [WIN];
  logic [CNT_W-1:0]  sh_count = '0;

  sequence_reorder_buffer_core #(
    .WINDOW(WIN)
  ) i_dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_n),
    .cfg_we_i            (cfg_we),
    .cfg_wdata_i         (cfg_wdata),
    .start               (start_r),
    .busy                (busy),
    .sequence_req_i      (seq_r),
    .channel_i           (chan_r),
    .magic_ok_i          (magic_r),
    .integrity_ok_i      (integ_r),
    .payload_handle_i    (hdl_r),
    .payload_length_i    (len_r),
    .strobe_o            (strobe_o),
    .status_o            (status_o),
    .delivered_sequence_o(delivered_sequence_o),
    .out_handle_o        (out_handle_o),
    .out_length_o        (out_length_o),
    .last_o              (last_o),
    .reorder_total_o     (reorder_total_o)
  );

  // clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic desc_t mk_desc(logic [SEQ_W-1:0] seq, logic [CHAN_W-1:0] chan,
                                    logic magic, logic integ,
                                    logic [HDL_W-1:0] hdl, logic [LEN_W-1:0] len);
    desc_t dsc;
    dsc.seq = seq;
    dsc.chan = chan;
    dsc.magic = magic;
    dsc.integ = integ;
    dsc.hdl = hdl;
    dsc.len = len;
    return dsc;
  endfunction

  task automatic report_mismatch(string field, logic [31:0] want, logic [31:0] got);
    if (err_cnt < 100)
      $display("tb: mismatch on %s, expected %0h got %0h at %0t", field, want, got, $realtime);
    err_cnt++;
  endtask

  // classify one accepted descriptor and queue the results it releases
  task automatic classify_descriptor(input desc_t dsc);
    result_t r;
    logic [SEQ_W-1:0] d;
    logic [SEQ_W-1:0] nx;
    logic [SEQ_W-1:0] ahead;
    logic [SEQ_W-1:0] up;
    int unsigned idx;
    int n;
    r.status = srb_pkg::ST_DELIVERED;
    r.seq = dsc.seq;
    r.hdl = '0;
    r.len = '0;
    r.last = 1'b0;
    r.total = '0;
    if (!dsc.magic) begin
      r.status = srb_pkg::ST_BAD_MAGIC;
    end else if (dsc.chan != sh_target) begin
      r.status = srb_pkg::ST_WRONG_CHANNEL;
    end else if (!dsc.integ) begin
      r.status = srb_pkg::ST_BAD_INTEGRITY;
    end else begin
      d = dsc.seq - sh_expected;
      if (d == '0) begin
        // in order: deliver, then walk consecutive buffered slots
        r.hdl = dsc.hdl;
        r.len = dsc.len;
        sh_expected = dsc.seq + 1;
        sh_highest = dsc.seq;
        n = 1;
        while (n < WIN) begin
          nx = sh_expected;
          idx = nx % WIN;
          ahead = nx - sh_highest;
          if (!(sh_valid[idx] && (ahead <= WIN || ahead[SEQ_W-1])))
            break;
          r.total = sh_count;
          result_q.push_back(r);
          r.seq = nx;
          r.hdl = sh_hdl[idx];
          r.len = sh_len[idx];
          sh_valid[idx] = 1'b0;
          sh_expected = nx + 1;
          n++;
        end
      end else if (d < WIN) begin
        // future packet inside the window
        idx = dsc.seq % WIN;
        if (sh_valid[idx]) begin
          r.status = srb_pkg::ST_DUPLICATE;
        end else begin
          r.status = srb_pkg::ST_BUFFERED;
          sh_valid[idx] = 1'b1;
          sh_hdl[idx] = dsc.hdl;
          sh_len[idx] = dsc.len;
          if (sh_count != '1)
            sh_count++;
          up = dsc.seq - sh_highest;
          if (up != '0 && !up[SEQ_W-1])
            sh_highest = dsc.seq;
        end
      end else if ((32'd0 - d) < WIN) begin
        r.status = srb_pkg::ST_DUPLICATE;
      end else begin
        r.status = srb_pkg::ST_OUT_OF_WINDOW;
      end
    end
    r.last = 1'b1;
    r.total = sh_count;
    result_q.push_back(r);
  endtask

  // descriptor driver: bursts of random length with random gaps
  always @(posedge clk_i or negedge rst_n) begin
    if (!rst_n) begin
      start_r <= 1'b0;
    end else begin
      if (start_r && busy == 1'b0) begin
        classify_descriptor(cur_desc);
        burst_left--;
        if (burst_left <= 0) begin
          gap_left = $urandom_range(0, 8);
          burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
                                                   : $urandom_range(1, 6);
        end
      end
      if (!start_r || busy == 1'b0) begin
        if (gap_left > 0) begin
          gap_left--;
          start_r <= 1'b0;
        end else if (desc_q.size() != 0) begin
          cur_desc = desc_q.pop_front();
          seq_r <= cur_desc.seq;
          chan_r <= cur_desc.chan;
          magic_r <= cur_desc.magic;
          integ_r <= cur_desc.integ;
          hdl_r <= cur_desc.hdl;
          len_r <= cur_desc.len;
          start_r <= 1'b1;
        end else begin
          start_r <= 1'b0;
        end
      end
    end
  end

  // result monitor: every strobed transfer against the oldest expectation
  always @(posedge clk_i) begin
    result_t want;
    if (rst_n && strobe_o === 1'b1) begin
      if (result_q.size() == 0) begin
        report_mismatch("result with nothing pending, sequence", '0, delivered_sequence_o);
      end else begin
        want = result_q.pop_front();
        if (status_o !== want.status)
          report_mismatch("status", want.status, status_o);
        if (delivered_sequence_o !== want.seq)
          report_mismatch("delivered_sequence", want.seq, delivered_sequence_o);
        if (out_handle_o !== want.hdl)
          report_mismatch("out_handle", want.hdl, out_handle_o);
        if (out_length_o !== want.len)
          report_mismatch("out_length", want.len, out_length_o);
        if (last_o !== want.last)
          report_mismatch("last", want.last, last_o);
        if (reorder_total_o !== want.total)
          report_mismatch("reorder_total", want.total, reorder_total_o);
      end
    end
  end

  // wait until all descriptors are taken and all results are in
  task automatic wait_idle();
    while (desc_q.size() != 0 || start_r || result_q.size() != 0 || busy !== 1'b0)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_channel(logic [CHAN_W-1:0] value);
    @(posedge clk_i);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    sh_target = value;
  endtask

  // stimulus
  initial begin
    int phase_no;
    int n;
    int drop;
    int k;
    int j;
    int t;
    int rnd_items;
    logic [SEQ_W-1:0] base;
    logic [SEQ_W-1:0] s;
    int offs[$];
    logic [SEQ_W-1:0] sent[$];

    for (k = 0; k < WIN; k++) begin
      sh_valid[k] = 1'b0;
      sh_hdl[k] = '0;
      sh_len[k] = '0;
    end
    repeat (6) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);

    // directed: check order, slot handling, window edges, wrapped differences
    desc_q.push_back(mk_desc(32'hFFFF_FFFF, 16'hFFFF, 1'b0, 1'b0, 16'hFFFF, 16'hFFFF));
    desc_q.push_back(mk_desc(32'h0, 16'h0001, 1'b1, 1'b0, 16'h1234, 16'h0040));
    desc_q.push_back(mk_desc(32'h0, 16'h0000, 1'b1, 1'b0, 16'h1234, 16'h0040));
    desc_q.push_back(mk_desc(32'h0, 16'h0000, 1'b1, 1'b1, 16'hFFFF, 16'hFFFF));
    desc_q.push_back(mk_desc(32'h2, 16'h0000, 1'b1, 1'b1, 16'h0000, 16'h0000));
    desc_q.push_back(mk_desc(32'h2, 16'h0000, 1'b1, 1'b1, 16'h5555, 16'hAAAA));
    desc_q.push_back(mk_desc(32'h3, 16'h0000, 1'b1, 1'b1, 16'hAAAA, 16'h5555));
    desc_q.push_back(mk_desc(32'h1, 16'h0000, 1'b1, 1'b1, 16'h0101, 16'h0202));
    desc_q.push_back(mk_desc(32'h0, 16'h0000, 1'b1, 1'b1, 16'h0303, 16'h0404));
    desc_q.push_back(mk_desc(32'd35, 16'h0000, 1'b1, 1'b1, 16'h8000, 16'h7FFF));
    desc_q.push_back(mk_desc(32'd36, 16'h0000, 1'b1, 1'b1, 16'h0505, 16'h0606));
    desc_q.push_back(mk_desc(32'hFFFF_FFE5, 16'h0000, 1'b1, 1'b1, 16'h0707, 16'h0808));
    desc_q.push_back(mk_desc(32'hFFFF_FFE4, 16'h0000, 1'b1, 1'b1, 16'h0909, 16'h0A0A));
    desc_q.push_back(mk_desc(32'h8000_0004, 16'h0000, 1'b1, 1'b1, 16'h0B0B, 16'h0C0C));
    desc_q.push_back(mk_desc(32'h4, 16'h0000, 1'b1, 1'b1, 16'h0D0D, 16'h0E0E));
    wait_idle();

    write_channel(16'hFFFF);
    desc_q.push_back(mk_desc(32'h5, 16'hFFFF, 1'b1, 1'b1, 16'h7FFF, 16'h8000));
    desc_q.push_back(mk_desc(32'h6, 16'h0000, 1'b1, 1'b1, 16'h1111, 16'h2222));
    desc_q.push_back(mk_desc(32'h6, 16'hFFFF, 1'b0, 1'b1, 16'h3333, 16'h4444));
    wait_idle();

    // random: shuffled runs of consecutive sequences, with noise and broken runs
    rnd_items = 0;
    phase_no = 0;
    while (rnd_items < 140) begin
      phase_no++;
      case (phase_no % 4)
        0: write_channel(16'hFFFF);
        1: write_channel(16'h0000);
        default: write_channel(16'($urandom_range(0, 16'hFFFF)));
      endcase
      if (phase_no == 1)
        n = WIN;
      else if ($urandom_range(0, 7) == 0)
        n = $urandom_range(20, WIN);
      else
        n = $urandom_range(1, 8);
      base = sh_expected;
      offs.delete();
      sent.delete();
      for (k = 0; k < n; k++)
        offs.push_back(k);
      for (k = n - 1; k > 0; k--) begin
        j = $urandom_range(0, k);
        t = offs[k];
        offs[k] = offs[j];
        offs[j] = t;
      end
      drop = ($urandom_range(0, 4) == 0 && phase_no != 1) ? $urandom_range(0, n - 1) : -1;
      for (k = 0; k < n; k++) begin
        if ($urandom_range(0, 3) == 0) begin
          rnd_items++;
          case ($urandom_range(0, 5))
            0: desc_q.push_back(mk_desc($urandom, 16'($urandom_range(0, 16'hFFFF)), 1'b0,
                                        1'($urandom_range(0, 1)),
                                        16'($urandom_range(0, 16'hFFFF)),
                                        16'($urandom_range(0, 16'hFFFF))));
            1: desc_q.push_back(mk_desc(base + k,
                                        sh_target ^ 16'($urandom_range(1, 16'hFFFF)), 1'b1,
                                        1'($urandom_range(0, 1)),
                                        16'($urandom_range(0, 16'hFFFF)),
                                        16'($urandom_range(0, 16'hFFFF))));
            2: desc_q.push_back(mk_desc(base + k, sh_target, 1'b1, 1'b0,
                                        16'($urandom_range(0, 16'hFFFF)),
                                        16'($urandom_range(0, 16'hFFFF))));
            3: desc_q.push_back(mk_desc($urandom, sh_target, 1'b1, 1'b1,
                                        16'($urandom_range(0, 16'hFFFF)),
                                        16'($urandom_range(0, 16'hFFFF))));
            4: desc_q.push_back(mk_desc(base - $urandom_range(1, WIN + 8), sh_target,
                                        1'b1, 1'b1, 16'($urandom_range(0, 16'hFFFF)),
                                        16'($urandom_range(0, 16'hFFFF))));
            default: desc_q.push_back(mk_desc((sent.size() != 0) ?
                                              sent[$urandom_range(0, sent.size() - 1)] :
                                              base, sh_target, 1'b1, 1'b1,
                                              16'($urandom_range(0, 16'hFFFF)),
                                              16'($urandom_range(0, 16'hFFFF))));
          endcase
        end
        if (k != drop) begin
          s = base + offs[k];
          desc_q.push_back(mk_desc(s, sh_target, 1'b1, 1'b1,
                                   16'($urandom_range(0, 16'hFFFF)),
                                   16'($urandom_range(0, 16'hFFFF))));
          sent.push_back(s);
          rnd_items++;
        end
      end
      wait_idle();
    end

    if (err_cnt == 0)
      $display("tb: PASS");
    else
      $display("tb: FAIL");
    $finish;
  end

  // watchdog
  initial begin
    #2_000_000;
    $display("tb: FAIL");
    $finish;
  end

endmodule
